>>> rtl/wda_pkg.sv
package wda_pkg;

  localparam int unsigned MAX_WINDOW_PAIRS = 512;

  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned THR_W    = 8;
  localparam int unsigned SUM_W    = 18;
  localparam int unsigned SQ_ACC_W = 27;
  localparam int unsigned SQ_OUT_W = 26;
  localparam int unsigned N_W      = CNT_W + 1;
  localparam int unsigned LHS_W    = N_W + SQ_ACC_W;
  localparam int unsigned S2_W     = 2 * SUM_W;
  localparam int unsigned TN_W     = THR_W + N_W;
  localparam int unsigned LIM_W    = 2 * TN_W;

  localparam int unsigned CNT_MAX   = (1 << CNT_W) - 1;
  localparam int unsigned PAIRS_CAP =
      (MAX_WINDOW_PAIRS > CNT_MAX) ? CNT_MAX : MAX_WINDOW_PAIRS;

  localparam int unsigned PAIRS_RESET = 400;
  localparam int unsigned THR_RESET   = 20;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_PAIRS        = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION_THRESHOLD = 2'd1;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 48;

  typedef struct packed {
    logic acc_en;
    logic close;
    logic mul_en;
    logic sub_en;
    logic out_load;
  } cmd_t;

endpackage

>>> rtl/windowed_deviation_alarm.sv
// Windowed deviation alarm. Each request carries one X and one Y accelerometer byte;
// the block adds both to a running sum and sum of squares and counts pairs. When the
// configured number of pairs is reached it emits one result with the window sum, the
// sum of squares and an alarm bit that is set when the population standard deviation
// exceeds the threshold, tested exactly as N*sumsq - sum^2 > (thr*N)^2 with
// N = 2 * pairs, and it clears its accumulators. A window length of zero acts as one,
// one above 512 as 512. Samples inside a window are taken one per cycle. The sample
// that closes a window is accumulated and then occupies the block through the
// multiply, subtract and compare steps of the datapath; the next request is taken
// once the result has moved to the output register, a move that waits only while
// an earlier result is still held there. Configuration writes are always ready and
// should be issued while no window result is pending.
module windowed_deviation_alarm (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [7:0] x_sample, [15:8] y_sample
  input  logic [wda_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [0] alarm, [18:1] window_sum, [44:19] window_square_sum, [47:45] zero
  output logic [wda_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [wda_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wda_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned PAD_W = wda_pkg::OUT_DATA_W - 1 - wda_pkg::SUM_W -
                                  wda_pkg::SQ_OUT_W;

  logic [wda_pkg::CNT_W-1:0]    window_pairs_q, window_pairs_d;
  logic [wda_pkg::THR_W-1:0]    threshold_q, threshold_d;
  wda_pkg::cmd_t                cmd;
  logic                         close_hit;
  logic                         alarm;
  logic [wda_pkg::SUM_W-1:0]    window_sum;
  logic [wda_pkg::SQ_OUT_W-1:0] window_square_sum;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    window_pairs_d = window_pairs_q;
    threshold_d    = threshold_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        wda_pkg::CFG_WINDOW_PAIRS: begin
          window_pairs_d = cfg_data_i[wda_pkg::CNT_W-1:0];
        end
        wda_pkg::CFG_DEVIATION_THRESHOLD: begin
          threshold_d = cfg_data_i[wda_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_pairs_q <= wda_pkg::CNT_W'(wda_pkg::PAIRS_RESET);
      threshold_q    <= wda_pkg::THR_W'(wda_pkg::THR_RESET);
    end else begin
      window_pairs_q <= window_pairs_d;
      threshold_q    <= threshold_d;
    end
  end

  wda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .close_hit_i (close_hit),
    .cmd_o       (cmd)
  );

  wda_datapath u_datapath (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .x_sample_i            (s_axis_tdata_i[wda_pkg::SAMPLE_W-1:0]),
    .y_sample_i            (s_axis_tdata_i[2*wda_pkg::SAMPLE_W-1:wda_pkg::SAMPLE_W]),
    .window_pairs_i        (window_pairs_q),
    .deviation_threshold_i (threshold_q),
    .close_hit_o           (close_hit),
    .alarm_o               (alarm),
    .window_sum_o          (window_sum),
    .window_square_sum_o   (window_square_sum)
  );

  assign m_axis_tdata_o = {{PAD_W{1'b0}}, window_square_sum, window_sum, alarm};

endmodule

>>> rtl/wda_ctrl.sv
module wda_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  logic          close_hit_i,
  output wda_pkg::cmd_t cmd_o
);

  localparam logic [1:0] S_ACC = 2'd0;
  localparam logic [1:0] S_MUL = 2'd1;
  localparam logic [1:0] S_SUB = 2'd2;
  localparam logic [1:0] S_CMP = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_ACC: begin
        in_ready_o   = 1'b1;
        cmd_o.acc_en = in_valid_i;
        if (in_valid_i && close_hit_i) begin
          cmd_o.close = 1'b1;
          state_d     = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = S_SUB;
      end
      S_SUB: begin
        cmd_o.sub_en = 1'b1;
        state_d      = S_CMP;
      end
      S_CMP: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_ACC;
        end
      end
      default: begin
        state_d = S_ACC;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_close_starts_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && close_hit_i) |=> (state_q == S_MUL))
    else $error("window close did not start the alarm computation");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_no_accum_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_ACC) |-> (!cmd_o.acc_en && !cmd_o.close))
    else $error("sample accumulated during alarm computation");
`endif

endmodule

>>> rtl/wda_datapath.sv
module wda_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wda_pkg::cmd_t                   cmd_i,
  input  logic [wda_pkg::SAMPLE_W-1:0]    x_sample_i,
  input  logic [wda_pkg::SAMPLE_W-1:0]    y_sample_i,
  input  logic [wda_pkg::CNT_W-1:0]       window_pairs_i,
  input  logic [wda_pkg::THR_W-1:0]       deviation_threshold_i,
  output logic                            close_hit_o,
  output logic                            alarm_o,
  output logic [wda_pkg::SUM_W-1:0]       window_sum_o,
  output logic [wda_pkg::SQ_OUT_W-1:0]    window_square_sum_o
);

  localparam int unsigned SQ_SMP_W = 2 * wda_pkg::SAMPLE_W;

  logic [wda_pkg::CNT_W-1:0]    pair_count_q, pair_count_d;
  logic [wda_pkg::SUM_W-1:0]    sum_acc_q, sum_acc_d;
  logic [wda_pkg::SQ_ACC_W-1:0] sq_acc_q, sq_acc_d;
  logic [wda_pkg::CNT_W-1:0]    pairs_eff;
  logic [SQ_SMP_W-1:0]          x_sq, y_sq;
  logic [wda_pkg::SUM_W-1:0]    sum_next;
  logic [wda_pkg::SQ_ACC_W-1:0] sq_next;
  logic [wda_pkg::CNT_W-1:0]    count_next;

  logic [wda_pkg::SUM_W-1:0]    sum_op_q;
  logic [wda_pkg::SQ_ACC_W-1:0] sq_op_q;
  logic [wda_pkg::N_W-1:0]      n_q;
  logic [wda_pkg::LHS_W-1:0]    lhs_q;
  logic [wda_pkg::S2_W-1:0]     s2_q;
  logic [wda_pkg::TN_W-1:0]     tn_q;
  logic [wda_pkg::LIM_W-1:0]    lim_q;
  logic [wda_pkg::LHS_W-1:0]    diff_q;
  logic                         pos_q;
  logic                         alarm_q;
  logic [wda_pkg::SUM_W-1:0]    out_sum_q;
  logic [wda_pkg::SQ_OUT_W-1:0] out_sq_q;

  always_comb begin
    pairs_eff = window_pairs_i;
    if (window_pairs_i == '0) begin
      pairs_eff = wda_pkg::CNT_W'(1);
    end else if (window_pairs_i > wda_pkg::CNT_W'(wda_pkg::PAIRS_CAP)) begin
      pairs_eff = wda_pkg::CNT_W'(wda_pkg::PAIRS_CAP);
    end
  end

  assign x_sq       = {{wda_pkg::SAMPLE_W{1'b0}}, x_sample_i} *
                      {{wda_pkg::SAMPLE_W{1'b0}}, x_sample_i};
  assign y_sq       = {{wda_pkg::SAMPLE_W{1'b0}}, y_sample_i} *
                      {{wda_pkg::SAMPLE_W{1'b0}}, y_sample_i};
  assign sum_next   = sum_acc_q + wda_pkg::SUM_W'(x_sample_i) + wda_pkg::SUM_W'(y_sample_i);
  assign sq_next    = sq_acc_q + wda_pkg::SQ_ACC_W'(x_sq) + wda_pkg::SQ_ACC_W'(y_sq);
  assign count_next = pair_count_q + wda_pkg::CNT_W'(1);
  assign close_hit_o = (count_next >= pairs_eff);

  always_comb begin
    pair_count_d = pair_count_q;
    sum_acc_d    = sum_acc_q;
    sq_acc_d     = sq_acc_q;
    if (cmd_i.close) begin
      pair_count_d = '0;
      sum_acc_d    = '0;
      sq_acc_d     = '0;
    end else if (cmd_i.acc_en) begin
      pair_count_d = count_next;
      sum_acc_d    = sum_next;
      sq_acc_d     = sq_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pair_count_q <= '0;
      sum_acc_q    <= '0;
      sq_acc_q     <= '0;
    end else begin
      pair_count_q <= pair_count_d;
      sum_acc_q    <= sum_acc_d;
      sq_acc_q     <= sq_acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.close) begin
      sum_op_q <= sum_next;
      sq_op_q  <= sq_next;
      n_q      <= {pairs_eff, 1'b0};
    end
    if (cmd_i.mul_en) begin
      lhs_q <= wda_pkg::LHS_W'(n_q) * wda_pkg::LHS_W'(sq_op_q);
      s2_q  <= wda_pkg::S2_W'(sum_op_q) * wda_pkg::S2_W'(sum_op_q);
      tn_q  <= wda_pkg::TN_W'(deviation_threshold_i) * wda_pkg::TN_W'(n_q);
    end
    if (cmd_i.sub_en) begin
      lim_q  <= wda_pkg::LIM_W'(tn_q) * wda_pkg::LIM_W'(tn_q);
      pos_q  <= (lhs_q > wda_pkg::LHS_W'(s2_q));
      diff_q <= lhs_q - wda_pkg::LHS_W'(s2_q);
    end
    if (cmd_i.out_load) begin
      alarm_q   <= pos_q && (wda_pkg::LIM_W'(diff_q) > lim_q);
      out_sum_q <= sum_op_q;
      out_sq_q  <= sq_op_q[wda_pkg::SQ_OUT_W-1:0];
    end
  end

  assign alarm_o             = alarm_q;
  assign window_sum_o        = out_sum_q;
  assign window_square_sum_o = out_sq_q;

`ifndef SYNTH
  a_clear_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.close |=> (sum_acc_q == '0 && sq_acc_q == '0 && pair_count_q == '0))
    else $error("accumulators not cleared at window close");
`endif

endmodule
